// ===== rtl/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_END    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // Pattern wildcard symbols
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

  // One input word as it leaves the input register
  typedef struct packed {
    logic       fire;
    action_e    action;
    logic [7:0] symbol;
  } step_t;

endpackage

// ===== rtl/wgm_if.sv =====
// Valid/ready channel interfaces for the matcher's input and result words.
interface wgm_in_if;
  logic              valid;
  logic              ready;
  wgm_pkg::action_e  action;
  logic [7:0]        symbol;

  modport source (output valid, action, symbol, input ready);
  modport sink   (input valid, action, symbol, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

// ===== rtl/wgm_pattern.sv =====
// Pattern storage: symbol registers, length, empty-text start vector, overflow flag.
module wgm_pattern #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wgm_pkg::step_t                         step_i,
  output logic [MAX_PATTERN-1:0][7:0]            store_o,
  output logic [$clog2(MAX_PATTERN + 1)-1:0]     len_o,
  output logic [MAX_PATTERN:0]                   start_d_o,
  output logic                                   overflow_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned VecW = MAX_PATTERN + 1;

  logic [MAX_PATTERN-1:0][7:0] store_q;
  logic [LenW-1:0]             len_q, len_d;
  logic [VecW-1:0]             start_q, start_d;
  logic                        ovf_q, ovf_d;
  logic                        full;
  logic                        do_append;

  assign full      = (len_q == LenW'(MAX_PATTERN));
  assign do_append = step_i.fire && (step_i.action == wgm_pkg::ACT_APPEND);

  // Next length, start vector and overflow flag
  always_comb begin
    len_d   = len_q;
    start_d = start_q;
    ovf_d   = ovf_q;
    if (step_i.fire) begin
      case (step_i.action)
        wgm_pkg::ACT_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
            // new prefix matches empty text only through a run of stars
            for (int j = 0; j < MAX_PATTERN; j++) begin
              if (len_q == LenW'(j)) begin
                start_d[j+1] = (step_i.symbol == wgm_pkg::SYM_STAR) && start_q[j];
              end
            end
          end
        end
        wgm_pkg::ACT_CLEAR: begin
          len_d   = '0;
          ovf_d   = 1'b0;
          start_d = VecW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      start_q <= VecW'(1);
      ovf_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      start_q <= start_d;
      ovf_q   <= ovf_d;
    end
  end

  // Symbol registers, written at the current length; no reset needed
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (do_append && !full && (len_q == LenW'(j))) begin
        store_q[j] <= step_i.symbol;
      end
    end
  end

  assign store_o    = store_q;
  assign len_o      = len_q;
  assign start_d_o  = start_d;
  assign overflow_o = ovf_q;

endmodule

// ===== rtl/wgm_prefix.sv =====
// Prefix-match vector: one lane per pattern position, stepped per text word, else reloaded.
module wgm_prefix #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wgm_pkg::step_t                         step_i,
  input  logic [MAX_PATTERN-1:0][7:0]            store_i,
  input  logic [$clog2(MAX_PATTERN + 1)-1:0]     len_i,
  input  logic [MAX_PATTERN:0]                   start_d_i,
  output logic                                   hit_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned VecW = MAX_PATTERN + 1;

  logic [VecW-1:0] prefix_q, prefix_d;
  logic [VecW-1:0] nxt;

  // Lane j: a star carries the bit from below (carry-style chain),
  // any other symbol moves the bit up one place on a match
  assign nxt[0] = 1'b0;
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic is_star, sym_hit, active;
    assign is_star = (store_i[j] == wgm_pkg::SYM_STAR);
    assign sym_hit = (store_i[j] == step_i.symbol) || (store_i[j] == wgm_pkg::SYM_ANY);
    assign active  = (LenW'(j) < len_i);
    assign nxt[j+1] = active && (is_star ? (prefix_q[j+1] || nxt[j])
                                         : (prefix_q[j] && sym_hit));
  end

  // Text words advance the vector; every other word reloads the start vector
  always_comb begin
    prefix_d = prefix_q;
    if (step_i.fire) begin
      if (step_i.action == wgm_pkg::ACT_TEXT) begin
        prefix_d = nxt;
      end else begin
        prefix_d = start_d_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= VecW'(1);
    end else begin
      prefix_q <= prefix_d;
    end
  end

  assign hit_o = prefix_q[len_i];

endmodule

// ===== rtl/wildcard_glob_matcher.sv =====
// Wildcard glob matcher top level: input register, pattern and prefix lanes, result register.
//
// Load a pattern with append words after a clear ('?' matches any one byte,
// '*' any run including none), then stream text bytes and close each text
// with an end word, which returns one result word (matched, pattern_overflow);
// other words return nothing. One word is taken every cycle with no gaps, unless an end
// word waits in the input register for a full, stalled result slot. A word is registered
// at the input, then all MAX_PATTERN position lanes of the prefix vector update together
// from that register, and an end word's result is captured in the result register. The
// critical path is the carry-like OR chain through consecutive '*' lanes, MAX_PATTERN
// positions long. An append beyond MAX_PATTERN symbols is dropped and flags overflow until
// the next clear; an append in the middle of a text discards that text.
module wildcard_glob_matcher #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wgm_in_if.sink        in_i,
  wgm_out_if.source     out_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic                        in_vld_q;
  wgm_pkg::action_e            in_act_q;
  logic [7:0]                  in_sym_q;
  logic                        advance;
  wgm_pkg::step_t              step;

  logic [MAX_PATTERN-1:0][7:0] store;
  logic [LenW-1:0]             len;
  logic [MAX_PATTERN:0]        start_d;
  logic                        ovf;
  logic                        hit;

  logic                        out_vld_q;
  logic                        matched_q;
  logic                        ovf_q;

  // Input word moves on unless it is an end word blocked by a full result slot
  assign advance = in_vld_q &&
                   ((in_act_q != wgm_pkg::ACT_END) || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_act_q <= in_i.action;
      in_sym_q <= in_i.symbol;
    end
  end

  assign step.fire   = advance;
  assign step.action = in_act_q;
  assign step.symbol = in_sym_q;

  wgm_pattern #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .store_o    (store),
    .len_o      (len),
    .start_d_o  (start_d),
    .overflow_o (ovf)
  );

  wgm_prefix #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_prefix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .store_i   (store),
    .len_i     (len),
    .start_d_i (start_d),
    .hit_o     (hit)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && (in_act_q == wgm_pkg::ACT_END)) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (in_act_q == wgm_pkg::ACT_END)) begin
      matched_q <= !ovf && hit;
      ovf_q     <= ovf;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = ovf_q;

endmodule

// ===== rtl/wgm_checker.sv =====
// Port-level checks for the wildcard glob matcher, bound to the top level.
module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_overflow_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_matched_i) && $stable(out_overflow_i))
    else $error("result word changed while stalled");

  // Overflow forces no-match
  a_ovf_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_matched_i && out_overflow_i))
    else $error("match reported with pattern overflow");

  // Input is never stalled while the result slot is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result slot");

  // A fresh result follows an end word taken through the input and result registers
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |->
      $past(in_valid_i && in_ready_i && (in_action_i == wgm_pkg::ACT_END), 2))
    else $error("result without a matching end word");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_matched_i  (out_o.matched),
  .out_overflow_i (out_o.pattern_overflow)
);

// ===== tb/tb_wildcard_glob_matcher.sv =====
// Self-checking testbench for the wildcard glob matcher: directed table, then random sessions.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher;

  localparam int unsigned GLOB_CAP = 32;
  localparam int unsigned RANDOM_WORDS = 280;
  localparam logic [GLOB_CAP:0] PREFIX_START = {{GLOB_CAP{1'b0}}, 1'b1};

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct {
    wgm_pkg::action_e act;
    logic [7:0]       sym;
    int               reps;
    bit               typed;
    verdict_t         verdict;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  wgm_in_if  word_in ();
  wgm_out_if word_out ();

  wildcard_glob_matcher #(
    .MAX_PATTERN(GLOB_CAP)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (word_in),
    .out_o (word_out)
  );

  // Predictor state: stored pattern and the two prefix vectors
  logic [7:0]        glob_pat [GLOB_CAP];
  int unsigned       glob_len;
  logic [GLOB_CAP:0] live_prefix;
  logic [GLOB_CAP:0] empty_prefix;
  logic              glob_ovf;

  verdict_t verdicts_due[$];
  int       fail_count;
  int       words_sent;
  int       send_idle_pct;
  int       recv_stall_pct;

  // Opening table: typed verdicts only where obvious, the rest from the predictor
  stim_row_t opening_rows [30] = '{
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b1, 1'b0}}, // empty, empty
    '{wgm_pkg::ACT_TEXT,   8'h00,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'hFF,             1,  1'b1, '{1'b0, 1'b0}}, // empty, one byte
    '{wgm_pkg::ACT_APPEND, wgm_pkg::SYM_STAR, 1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b1, 1'b0}}, // star, empty text
    '{wgm_pkg::ACT_TEXT,   8'hFF,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_TEXT,   wgm_pkg::SYM_STAR, 1,  1'b0, '{1'b0, 1'b0}}, // literal star
    '{wgm_pkg::ACT_END,    8'h5A,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_CLEAR,  8'hC3,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, wgm_pkg::SYM_ANY,  1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, 8'h41,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_TEXT,   8'h41,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, wgm_pkg::SYM_STAR, 1,  1'b0, '{1'b0, 1'b0}}, // mid-text append
    '{wgm_pkg::ACT_TEXT,   8'h7E,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_TEXT,   8'h41,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b0, '{1'b0, 1'b0}}, // back-to-back end
    '{wgm_pkg::ACT_CLEAR,  8'h3C,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, wgm_pkg::SYM_STAR, 33, 1'b0, '{1'b0, 1'b0}}, // one past capacity
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b0, 1'b1}},
    '{wgm_pkg::ACT_TEXT,   8'h55,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b0, 1'b1}}, // flag sticks
    '{wgm_pkg::ACT_CLEAR,  8'h00,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, 8'h80,             32, 1'b0, '{1'b0, 1'b0}}, // exactly full
    '{wgm_pkg::ACT_TEXT,   8'h80,             32, 1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_APPEND, 8'h01,             1,  1'b0, '{1'b0, 1'b0}}, // refused append
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b0, 1'b1}},
    '{wgm_pkg::ACT_CLEAR,  8'hFF,             1,  1'b0, '{1'b0, 1'b0}},
    '{wgm_pkg::ACT_END,    8'h00,             1,  1'b1, '{1'b1, 1'b0}}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Advance the predictor by one accepted word
  task automatic glob_step(input wgm_pkg::action_e act, input logic [7:0] sym,
                           output bit emits, output verdict_t v);
    logic [GLOB_CAP:0] nxt;
    int unsigned j;
    emits = 1'b0;
    v = '0;
    nxt = '0;
    case (act)
      wgm_pkg::ACT_APPEND: begin
        if (glob_len >= GLOB_CAP) begin
          glob_ovf = 1'b1;
        end else begin
          glob_pat[glob_len] = sym;
          empty_prefix[glob_len + 1] = (sym == wgm_pkg::SYM_STAR) && empty_prefix[glob_len];
          glob_len++;
        end
        live_prefix = empty_prefix;
      end
      wgm_pkg::ACT_TEXT: begin
        // ascending, so a star picks up the bit set just below it
        for (j = 0; j < glob_len; j++) begin
          if (glob_pat[j] == wgm_pkg::SYM_STAR)
            nxt[j + 1] = live_prefix[j + 1] || nxt[j];
          else
            nxt[j + 1] = live_prefix[j] &&
                         (glob_pat[j] == sym || glob_pat[j] == wgm_pkg::SYM_ANY);
        end
        live_prefix = nxt;
      end
      wgm_pkg::ACT_END: begin
        v.matched = !glob_ovf && live_prefix[glob_len];
        v.overflow = glob_ovf;
        emits = 1'b1;
        live_prefix = empty_prefix;
      end
      default: begin
        glob_len = 0;
        glob_ovf = 1'b0;
        empty_prefix = PREFIX_START;
        live_prefix = PREFIX_START;
      end
    endcase
  endtask

  // Send one word; called in the step of a rising edge, returns in the step of acceptance
  task automatic put_word(input wgm_pkg::action_e act, input logic [7:0] sym,
                          input bit typed, input verdict_t typed_v);
    verdict_t v;
    bit emits;
    while ($urandom_range(99) < send_idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid  <= 1'b1;
    word_in.action <= act;
    word_in.symbol <= sym;
    do @(negedge clk_i); while (!word_in.ready);
    glob_step(act, sym, emits, v);
    if (emits) verdicts_due.push_back(typed ? typed_v : v);
    words_sent++;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every verdict is back
  task automatic drain_results();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // Text byte, biased toward the pattern alphabet
  function automatic logic [7:0] pick_text_sym();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(2));
    if (r < 80) return wgm_pkg::SYM_STAR;
    return 8'($urandom_range(255));
  endfunction

  // Result receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_out.ready <= 1'b0;
    end else begin
      word_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result check; values at the falling edge hold through the next rising edge
  always @(negedge clk_i) begin
    verdict_t want;
    if (rst_ni && word_out.valid && word_out.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result word matched=%0b overflow=%0b",
                 $time, word_out.matched, word_out.pattern_overflow);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (word_out.matched !== want.matched) begin
          $display("%0t: matched expected %0b actual %0b",
                   $time, want.matched, word_out.matched);
          fail_count++;
        end
        if (word_out.pattern_overflow !== want.overflow) begin
          $display("%0t: pattern_overflow expected %0b actual %0b",
                   $time, want.overflow, word_out.pattern_overflow);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] pat_q[$];
    logic [7:0] p;
    int plen, ntexts, tlen, k, m, n, r, rand_base;
    rst_ni         = 1'b0;
    word_in.valid  = 1'b0;
    word_in.action = wgm_pkg::ACT_APPEND;
    word_in.symbol = 8'h00;
    fail_count     = 0;
    words_sent     = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 61;
    glob_len       = 0;
    glob_ovf       = 1'b0;
    empty_prefix   = PREFIX_START;
    live_prefix    = PREFIX_START;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (opening_rows[i]) begin
      for (k = 0; k < opening_rows[i].reps; k++)
        put_word(opening_rows[i].act, opening_rows[i].sym, opening_rows[i].typed,
                 opening_rows[i].verdict);
    end

    // Random sessions; idle profile switches by thirds with a full drain in between
    rand_base = words_sent;
    while (words_sent - rand_base < RANDOM_WORDS) begin
      if (send_idle_pct == 10 && words_sent - rand_base >= RANDOM_WORDS / 3) begin
        drain_results();
        send_idle_pct  = 61;
        recv_stall_pct = 10;
      end else if (send_idle_pct == 61 && words_sent - rand_base >= 2 * RANDOM_WORDS / 3) begin
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      if ($urandom_range(99) < 15) begin
        // noise: any action with any byte
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          put_word(wgm_pkg::action_e'($urandom_range(3)), 8'($urandom_range(255)),
                   1'b0, '0);
      end else begin
        // well-formed: clear, pattern, then a few texts each closed by an end
        put_word(wgm_pkg::ACT_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
        plen = ($urandom_range(99) < 90) ? $urandom_range(0, 8) : $urandom_range(28, 36);
        pat_q.delete();
        for (k = 0; k < plen; k++) begin
          r = $urandom_range(99);
          if (r < 25)      p = wgm_pkg::SYM_STAR;
          else if (r < 45) p = wgm_pkg::SYM_ANY;
          else if (r < 90) p = 8'h61 + 8'($urandom_range(2));
          else             p = 8'($urandom_range(255));
          pat_q.push_back(p);
          put_word(wgm_pkg::ACT_APPEND, p, 1'b0, '0);
        end
        ntexts = $urandom_range(1, 4);
        for (k = 0; k < ntexts; k++) begin
          if ($urandom_range(1) == 1) begin
            // text built to fit the pattern
            foreach (pat_q[q]) begin
              if (pat_q[q] == wgm_pkg::SYM_STAR) begin
                tlen = $urandom_range(0, 3);
                for (m = 0; m < tlen; m++)
                  put_word(wgm_pkg::ACT_TEXT, pick_text_sym(), 1'b0, '0);
              end else if (pat_q[q] == wgm_pkg::SYM_ANY) begin
                put_word(wgm_pkg::ACT_TEXT, pick_text_sym(), 1'b0, '0);
              end else begin
                put_word(wgm_pkg::ACT_TEXT, pat_q[q], 1'b0, '0);
              end
            end
          end else begin
            tlen = $urandom_range(0, 10);
            for (m = 0; m < tlen; m++)
              put_word(wgm_pkg::ACT_TEXT, pick_text_sym(), 1'b0, '0);
          end
          put_word(wgm_pkg::ACT_END, 8'($urandom_range(255)), 1'b0, '0);
        end
      end
    end

    // Wrap up: all verdicts back, then a wait for stray words
    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wgm_pkg.sv
rtl/wgm_if.sv
rtl/wgm_pattern.sv
rtl/wgm_prefix.sv
rtl/wildcard_glob_matcher.sv
rtl/wgm_checker.sv
tb/tb_wildcard_glob_matcher.sv
